/* hw/rtl/assert_macros.svh */
// assertion macros shared by the colormap rtl
// no dependencies; included by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property that must hold on every clock edge out of reset
`define SGCM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("sgcm assertion failed");
// antecedent implies consequent in the same cycle
`define SGCM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgcm implication failed");
`else
`define SGCM_ASSERT(lbl, clk, rst, prop)
`define SGCM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/sgcm_pkg.sv */
// shared types and constants of the sonogram colormap pixel unit
// no dependencies; imported by every module of the block
package sgcm_pkg;

  // sample width and derived arithmetic widths
  localparam int SAMPLE_BITS = 16;
  localparam int OFF_W       = ((SAMPLE_BITS > 15) ? SAMPLE_BITS : 15) + 1;
  localparam int MAG_W       = OFF_W - 1;
  // reciprocal of 20, slightly low, corrected by one compare afterwards
  localparam int RECIP_W     = 16;
  localparam int RECIP_SH    = 20;
  localparam logic [RECIP_W-1:0] RECIP_20 = RECIP_W'((1 << RECIP_SH) / 20);
  localparam int PROD_W      = MAG_W + RECIP_W;
  localparam int Q_W         = PROD_W - RECIP_SH;
  localparam int TOP_W       = 12;
  localparam int IDX_W       = TOP_W - 1;
  localparam int BP_W        = 13;
  // segment length stays below 5121, so 13 bits and a 19 bit dividend
  localparam int DEN_W       = 13;
  localparam int QUO_W       = 6;
  localparam int DIV_W       = DEN_W + QUO_W;
  localparam int NUM_CELLS   = QUO_W;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_MIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_MAX      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_THRESHOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_ROWS_ON = 3'd4;
  localparam int CFG_DATA_W = 8;

  // reset values of the registers
  localparam logic signed [7:0] ENERGY_MIN_RST = -8'sd20;
  localparam logic signed [7:0] ENERGY_MAX_RST = 8'sd60;
  localparam logic signed [7:0] STOP_RST       = 8'sd10;
  localparam logic signed [7:0] SHAPE_RST      = 8'sd20;

  // colour constants
  localparam logic [7:0] RED_POINT      = 8'd224;
  localparam logic [7:0] GRAY_INIT_GOOD = 8'd230;
  localparam logic [7:0] GRAY_INIT_BAD  = 8'd25;
  localparam logic [7:0] GRAY_GOOD      = 8'd250;
  localparam logic [7:0] GRAY_BAD       = 8'd5;
  localparam logic [7:0] BLUE_OFFSET    = 8'd32;
  localparam logic [9:0] SILENCE_ROWS   = 10'd6;
  localparam logic [9:0] INIT_ROWS      = 10'd3;

  typedef struct packed {
    logic signed [7:0] energy_min;
    logic signed [7:0] energy_max;
    logic signed [7:0] stop_threshold;
    logic signed [7:0] shape_threshold;
    logic              silence_rows_on;
  } sgcm_cfg_t;

  // per-pixel side information carried along the divider chain
  typedef struct packed {
    logic       point;
    logic       silence;
    logic [7:0] gray;
    logic       oor;
    logic       hit;
    logic [1:0] seg;
  } sgcm_tag_t;

  // word handed from cell to cell
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] dsh;
    logic [QUO_W-1:0] quo;
    sgcm_tag_t        tag;
  } sgcm_word_t;

endpackage

/* hw/rtl/sgcm_front.sv */
// front pipeline: energy index, range check and segment search
// depends on sgcm_pkg; feeds the first divider cell
module sgcm_front import sgcm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  sgcm_cfg_t                     cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          point_flag,
  input  logic [9:0]                    row_number,
  input  logic                          good_column,
  input  logic                          good_column_initial,
  output logic                          dn_valid,
  output sgcm_word_t                    dn_word,
  input  logic                          dn_stall
);

  // stage registers
  logic                    a_valid, b_valid, c_valid, d_valid;
  logic signed [OFF_W-1:0] a_off;
  sgcm_tag_t               a_tag, b_tag, c_tag;
  logic [PROD_W-1:0]       b_prod;
  logic [MAG_W-1:0]        b_mag;
  logic                    b_neg, b_small;
  logic [IDX_W-1:0]        c_idx;
  sgcm_word_t              d_word;

  logic a_stall, b_stall, c_stall, d_stall;

  // stall chain, a stage holds only when full and blocked downstream
  assign d_stall  = d_valid & dn_stall;
  assign c_stall  = c_valid & d_stall;
  assign b_stall  = b_valid & c_stall;
  assign a_stall  = a_valid & b_stall;
  assign in_stall = a_stall;
  assign dn_valid = d_valid;
  assign dn_word  = d_word;

  // stage a: offset from the lower bound and silence row gray
  logic signed [OFF_W-1:0] samp_x, emin_x, hund;
  logic                    sil;
  logic [7:0]              gray;
  sgcm_tag_t               a_tag_next;

  always_comb begin
    samp_x = OFF_W'(sample);
    emin_x = OFF_W'(cfg.energy_min);
    hund   = (emin_x <<< 6) + (emin_x <<< 5) + (emin_x <<< 2);
    sil    = cfg.silence_rows_on && (row_number < SILENCE_ROWS);
    if (row_number < INIT_ROWS) begin
      gray = good_column_initial ? GRAY_INIT_GOOD : GRAY_INIT_BAD;
    end else begin
      gray = good_column ? GRAY_GOOD : GRAY_BAD;
    end
    a_tag_next         = '0;
    a_tag_next.point   = point_flag;
    a_tag_next.silence = sil;
    a_tag_next.gray    = gray;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!a_stall) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!a_stall) begin
      a_off <= samp_x - hund;
      a_tag <= a_tag_next;
    end
  end

  // stage b: magnitude times reciprocal of 20
  logic [MAG_W-1:0] a_mag;
  assign a_mag = a_off[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (!b_stall) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!b_stall) begin
      b_prod  <= PROD_W'(a_mag) * PROD_W'(RECIP_20);
      b_mag   <= a_mag;
      b_neg   <= a_off[OFF_W-1];
      b_small <= a_off > -OFF_W'(20);
      b_tag   <= a_tag;
    end
  end

  // stage c: quotient correction and range check
  logic [Q_W-1:0]          q0, idx;
  logic [MAG_W:0]          q20, rem20;
  logic signed [8:0]       span;
  logic signed [TOP_W-1:0] top;
  logic                    oor;
  sgcm_tag_t               c_tag_next;

  always_comb begin
    q0    = b_prod[PROD_W-1:RECIP_SH];
    q20   = ((MAG_W+1)'(q0) << 4) + ((MAG_W+1)'(q0) << 2);
    rem20 = (MAG_W+1)'(b_mag) - q20;
    idx   = (rem20 >= (MAG_W+1)'(20)) ? q0 + Q_W'(1) : q0;
    span  = 9'(cfg.energy_max) - 9'(cfg.energy_min);
    top   = (TOP_W'(span) <<< 2) + TOP_W'(span);
    if (b_neg) begin
      // offsets -19..-1 truncate to index zero, still above an inverted top
      oor = !b_small || top[TOP_W-1];
      idx = '0;
    end else begin
      oor = top[TOP_W-1] || (idx > Q_W'(top[TOP_W-2:0]));
    end
    c_tag_next     = b_tag;
    c_tag_next.oor = oor & !b_tag.silence;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (!c_stall) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!c_stall) begin
      c_idx <= idx[IDX_W-1:0];
      c_tag <= c_tag_next;
    end
  end

  // stage d: breakpoints, segment search and divider operands
  logic signed [BP_W-1:0] v, emin13, b1, b2, b3, b4, d2, d3, d4, lo, hi;
  logic [3:0]             inseg;
  logic                   hit;
  logic [1:0]             seg;
  logic [BP_W:0]          den_w, diff_w;
  logic [DEN_W-1:0]       den, diff;
  sgcm_word_t             d_word_next;

  always_comb begin
    v      = $signed({1'b0, c_idx, 1'b0});
    emin13 = BP_W'(cfg.energy_min);
    b1     = -((emin13 <<< 2) + emin13);
    d2     = BP_W'(cfg.stop_threshold) - emin13;
    d3     = BP_W'(cfg.shape_threshold) - emin13;
    d4     = BP_W'(cfg.energy_max) - emin13 + BP_W'(1);
    b2     = (d2 <<< 3) + (d2 <<< 1);
    b3     = (d3 <<< 3) + (d3 <<< 1);
    b4     = (d4 <<< 3) + (d4 <<< 1);
    inseg[0] = (v >= '0) && (v < b1);
    inseg[1] = (v >= b1) && (v < b2);
    inseg[2] = (v >= b2) && (v < b3);
    inseg[3] = (v >= b3) && (v < b4);
    hit = 1'b1;
    seg = 2'd0;
    lo  = '0;
    hi  = b1;
    // first segment that holds v wins
    if (inseg[0]) begin
      seg = 2'd0; lo = '0; hi = b1;
    end else if (inseg[1]) begin
      seg = 2'd1; lo = b1; hi = b2;
    end else if (inseg[2]) begin
      seg = 2'd2; lo = b2; hi = b3;
    end else if (inseg[3]) begin
      seg = 2'd3; lo = b3; hi = b4;
    end else begin
      hit = 1'b0;
    end
    den_w  = (BP_W+1)'(hi) - (BP_W+1)'(lo);
    diff_w = (BP_W+1)'(v) - (BP_W+1)'(lo);
    den    = den_w[DEN_W-1:0];
    diff   = diff_w[DEN_W-1:0];
    d_word_next         = '0;
    d_word_next.tag     = c_tag;
    d_word_next.tag.seg = seg;
    if (hit && !c_tag.oor) begin
      // rounded 32*diff/den as floor((64*diff + den) / (2*den))
      d_word_next.rem     = (DIV_W'(diff) << QUO_W) + DIV_W'(den);
      d_word_next.dsh     = DIV_W'(den) << QUO_W;
      d_word_next.tag.hit = 1'b1;
    end else begin
      d_word_next.rem     = '0;
      d_word_next.dsh     = '1;
      d_word_next.tag.hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (!d_stall) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!d_stall) begin
      d_word <= d_word_next;
    end
  end

endmodule

/* hw/rtl/sgcm_div_cell.sv */
// one restoring divider cell: settles one quotient bit per word
// depends on sgcm_pkg and assert_macros.svh; chained in the top level
`include "assert_macros.svh"
module sgcm_div_cell import sgcm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  input  sgcm_word_t up_word,
  output logic       up_stall,
  output logic       dn_valid,
  output sgcm_word_t dn_word,
  input  logic       dn_stall
);

  logic       valid;
  sgcm_word_t word;
  sgcm_word_t word_next;
  logic       ge;

  assign up_stall = valid & dn_stall;
  assign dn_valid = valid;
  assign dn_word  = word;

  // compare, subtract, shift the divisor down for the next cell
  always_comb begin
    ge            = up_word.rem >= up_word.dsh;
    word_next     = up_word;
    word_next.rem = ge ? up_word.rem - up_word.dsh : up_word.rem;
    word_next.dsh = up_word.dsh >> 1;
    word_next.quo = {up_word.quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall) begin
      word <= word_next;
    end
  end

  // partial remainder always below twice the shifted divisor
  logic [DIV_W:0] rem_x, dsh2;
  assign rem_x = (DIV_W+1)'(up_word.rem);
  assign dsh2  = (DIV_W+1)'(up_word.dsh) << 1;

  `SGCM_ASSERT_IMP(a_rem_bound, clk, rst, up_valid, rem_x < dsh2)
  `SGCM_ASSERT_IMP(a_miss_no_quo, clk, rst, valid && !word.tag.hit, word.quo == '0)

endmodule

/* hw/rtl/sonogram_colormap_pixel_unit.sv */
// sonogram colormap pixel unit: sample to rgb through a piecewise linear scale
// depends on sgcm_pkg, sgcm_front, sgcm_div_cell and assert_macros.svh
//
// usage:
//   input channel in_valid / in_stall carries one pixel word per accept:
//   sample, point_flag, row_number, good_column, good_column_initial.
//   output channel out_valid / out_stall returns one colour word per pixel
//   (red, green, blue, out_of_range), in order of arrival.
//   configuration: cfg_we writes cfg_data into register cfg_index
//   (0 energy_min, 1 energy_max, 2 stop_threshold, 3 shape_threshold,
//   4 silence_rows_on); write only while no pixel is in flight.
// timing:
//   an accepted pixel passes four front stages, six divider cells
//   (one quotient bit each) and the output register, which drives out_valid.
//   throughput is one pixel per clock unless out_stall holds the pipeline.
// reset: rst clears all pipeline valids and loads the register defaults.
// stall: out_stall holds the output word; the pipeline keeps filling its
//   empty stages and raises in_stall only when every stage is full.
`include "assert_macros.svh"
module sonogram_colormap_pixel_unit import sgcm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          point_flag,
  input  logic [9:0]                    row_number,
  input  logic                          good_column,
  input  logic                          good_column_initial,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    red,
  output logic [7:0]                    green,
  output logic [7:0]                    blue,
  output logic                          out_of_range
);

  // configuration registers
  sgcm_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.energy_min      <= ENERGY_MIN_RST;
      cfg.energy_max      <= ENERGY_MAX_RST;
      cfg.stop_threshold  <= STOP_RST;
      cfg.shape_threshold <= SHAPE_RST;
      cfg.silence_rows_on <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENERGY_MIN:      cfg.energy_min      <= $signed(cfg_data);
        REG_ENERGY_MAX:      cfg.energy_max      <= $signed(cfg_data);
        REG_STOP_THRESHOLD:  cfg.stop_threshold  <= $signed(cfg_data);
        REG_SHAPE_THRESHOLD: cfg.shape_threshold <= $signed(cfg_data);
        REG_SILENCE_ROWS_ON: cfg.silence_rows_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // chain links: link i feeds cell i, link NUM_CELLS feeds the output
  logic       cv [0:NUM_CELLS];
  sgcm_word_t cw [0:NUM_CELLS];
  logic       cs [0:NUM_CELLS];
  logic       o_stall;

  sgcm_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .cfg                 (cfg),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .sample              (sample),
    .point_flag          (point_flag),
    .row_number          (row_number),
    .good_column         (good_column),
    .good_column_initial (good_column_initial),
    .dn_valid            (cv[0]),
    .dn_word             (cw[0]),
    .dn_stall            (cs[0])
  );

  // row of divider cells, msb of the rounded fraction first
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    sgcm_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (cv[i]),
      .up_word  (cw[i]),
      .up_stall (cs[i]),
      .dn_valid (cv[i+1]),
      .dn_word  (cw[i+1]),
      .dn_stall (cs[i+1])
    );
  end

  assign o_stall        = out_valid & out_stall;
  assign cs[NUM_CELLS]  = o_stall;

  // colour assembly
  sgcm_word_t lw;
  logic [7:0] r_next, g_next, b_next;
  logic       oor_next;

  always_comb begin
    lw       = cw[NUM_CELLS];
    r_next   = lw.tag.point ? RED_POINT : 8'd0;
    g_next   = 8'd0;
    b_next   = 8'd0;
    oor_next = lw.tag.oor;
    if (lw.tag.silence) begin
      r_next   = lw.tag.gray;
      g_next   = lw.tag.gray;
      b_next   = lw.tag.gray;
      oor_next = 1'b0;
    end else if (lw.tag.hit) begin
      g_next = {1'b0, lw.tag.seg, 5'd0} + 8'(lw.quo);
      b_next = g_next + BLUE_OFFSET;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!o_stall) begin
      out_valid <= cv[NUM_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (!o_stall) begin
      red          <= r_next;
      green        <= g_next;
      blue         <= b_next;
      out_of_range <= oor_next;
    end
  end

  `SGCM_ASSERT_IMP(a_stall_only_full, clk, rst, in_stall, out_valid && out_stall)
  `SGCM_ASSERT_IMP(a_oor_black, clk, rst, out_valid && out_of_range, green == 8'd0 && blue == 8'd0)
  `SGCM_ASSERT(a_gray_equal, clk, rst, !(out_valid && red != RED_POINT && red != 8'd0) || (red == green && green == blue))

endmodule

/* dv/sonogram_colormap_pixel_unit_tb.sv */
// self-checking testbench for the sonogram colormap pixel unit
// drives pixel words, predicts each colour word and compares it field by field
// depends on sgcm_pkg and sonogram_colormap_pixel_unit
`timescale 1ns / 100ps

module sonogram_colormap_pixel_unit_tb;
  import sgcm_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRINT_LIMIT  = 40;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          point;
    logic [9:0]                    row;
    logic                          good;
    logic                          good_init;
  } pixel_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       oor;
  } colour_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] sample = '0;
  logic                          point_flag = 1'b0;
  logic [9:0]                    row_number = '0;
  logic                          good_column = 1'b0;
  logic                          good_column_initial = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [7:0]                    red;
  logic [7:0]                    green;
  logic [7:0]                    blue;
  logic                          out_of_range;

  // scale settings as the block should hold them
  int scale_min  = ENERGY_MIN_RST;
  int scale_max  = ENERGY_MAX_RST;
  int stop_db    = STOP_RST;
  int shape_db   = SHAPE_RST;
  bit silence_on = 1'b0;

  pixel_t  pixel_backlog[$];
  colour_t colour_due[$];
  pixel_t  drv_pixel;
  colour_t due;
  int      send_gap = 0;
  int      stall_left = 0;
  bit      send_idle = 1'b1;
  bit      recv_idle = 1'b1;
  int      mismatch_count = 0;
  int      cycle_count = 0;

  sonogram_colormap_pixel_unit u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .sample              (sample),
    .point_flag          (point_flag),
    .row_number          (row_number),
    .good_column         (good_column),
    .good_column_initial (good_column_initial),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .red                 (red),
    .green               (green),
    .blue                (blue),
    .out_of_range        (out_of_range)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // colour of one pixel under the current scale settings
  function automatic colour_t pixel_colour(pixel_t p);
    colour_t c;
    int      idx, top, v, den, num, frac;
    int      bp[5];
    bit      found;
    c = '{8'd0, 8'd0, 8'd0, 1'b0};
    found = 1'b0;
    if (silence_on && p.row < SILENCE_ROWS) begin
      // quality bars: initial flag low, final flag above
      if (p.row < INIT_ROWS)
        c.red = p.good_init ? GRAY_INIT_GOOD : GRAY_INIT_BAD;
      else
        c.red = p.good ? GRAY_GOOD : GRAY_BAD;
      c.green = c.red;
      c.blue  = c.red;
    end else begin
      // index in fifths of a dB, truncated toward zero
      idx = (int'($signed(p.sample)) - 100 * scale_min) / 20;
      top = 5 * (scale_max - scale_min);
      if (idx < 0 || idx > top) begin
        c.oor = 1'b1;
      end else begin
        v = 2 * idx;
        bp[0] = 0;
        bp[1] = -5 * scale_min;
        bp[2] = 10 * (stop_db - scale_min);
        bp[3] = 10 * (shape_db - scale_min);
        bp[4] = 10 * (scale_max + 1 - scale_min);
        // first segment holding v wins, rounded half up
        for (int k = 0; k < 4; k++) begin
          if (!found && v >= bp[k] && v < bp[k+1]) begin
            found  = 1'b1;
            den    = bp[k+1] - bp[k];
            num    = 32 * (v - bp[k]);
            frac   = (2 * num + den) / (2 * den);
            c.green = 8'(32 * k + frac);
            c.blue  = 8'(32 * k + frac + 32);
          end
        end
      end
      if (p.point)
        c.red = RED_POINT;
    end
    return c;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60)
      return 0;
    else if (r < 92)
      return $urandom_range(1, 3);
    else
      return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // sender: feed pixel words from the backlog, predict at accept
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall)
        colour_due.push_back(pixel_colour(drv_pixel));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pixel_backlog.size() != 0) begin
          drv_pixel           <= pixel_backlog[0];
          sample              <= pixel_backlog[0].sample;
          point_flag          <= pixel_backlog[0].point;
          row_number          <= pixel_backlog[0].row;
          good_column         <= pixel_backlog[0].good;
          good_column_initial <= pixel_backlog[0].good_init;
          void'(pixel_backlog.pop_front());
          in_valid <= 1'b1;
          send_gap <= pick_gap(send_idle);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each accepted colour word, stall at random when recv_idle
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (colour_due.size() == 0) begin
          report_mismatch("colour word with no pixel pending");
        end else begin
          due = colour_due.pop_front();
          if (red !== due.red)
            report_mismatch($sformatf("red %0d, expected %0d", red, due.red));
          if (green !== due.green)
            report_mismatch($sformatf("green %0d, expected %0d", green, due.green));
          if (blue !== due.blue)
            report_mismatch($sformatf("blue %0d, expected %0d", blue, due.blue));
          if (out_of_range !== due.oor)
            report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                      out_of_range, due.oor));
        end
      end
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 1'b0;
        if (recv_idle && $urandom_range(0, 3) == 0)
          stall_left <= pick_gap(1'b1);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
  endtask

  // program all five registers back to back, block idle
  task automatic load_scale(input int lo, input int hi, input int stp, input int shp,
                            input bit sil);
    write_reg(REG_ENERGY_MIN, lo);
    write_reg(REG_ENERGY_MAX, hi);
    write_reg(REG_STOP_THRESHOLD, stp);
    write_reg(REG_SHAPE_THRESHOLD, shp);
    write_reg(REG_SILENCE_ROWS_ON, int'(sil));
    @(posedge clk);
    cfg_we     <= 1'b0;
    scale_min  = lo;
    scale_max  = hi;
    stop_db    = stp;
    shape_db   = shp;
    silence_on = sil;
  endtask

  task automatic queue_pixel(input int s, input bit pt, input int row, input bit gd,
                             input bit gi);
    pixel_t p;
    p.sample    = SAMPLE_BITS'(s);
    p.point     = pt;
    p.row       = 10'(row);
    p.good      = gd;
    p.good_init = gi;
    pixel_backlog.push_back(p);
  endtask

  // random pixels, most of them around the scale and its breakpoints
  task automatic queue_random_pixels(input int n);
    int s, b, base, top, row;
    for (int i = 0; i < n; i++) begin
      base = 100 * scale_min;
      top  = 5 * (scale_max - scale_min);
      case ($urandom_range(0, 9))
        0, 1: s = int'($urandom_range(0, 65535)) - 32768;
        2, 3: begin
          case ($urandom_range(0, 4))
            0: b = 0;
            1: b = -5 * scale_min;
            2: b = 10 * (stop_db - scale_min);
            3: b = 10 * (shape_db - scale_min);
            default: b = 10 * (scale_max + 1 - scale_min);
          endcase
          s = base + 10 * b + int'($urandom_range(0, 60)) - 30;
        end
        default: begin
          if (top >= 0)
            s = base - 40 + int'($urandom_range(0, 20 * top + 100));
          else
            s = base + int'($urandom_range(0, 4000)) - 2000;
        end
      endcase
      if ($urandom_range(0, 1))
        row = $urandom_range(0, 7);
      else
        row = $urandom_range(0, 1023);
      queue_pixel(s, 1'($urandom_range(0, 1)), row, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    end
  endtask

  // wait until the backlog is sent and every colour word is back
  task automatic drain_pixels();
    do
      @(negedge clk);
    while (pixel_backlog.size() != 0 || in_valid || colour_due.size() != 0);
  endtask

  task automatic run_phase(input int n, input bit si, input bit ri);
    @(negedge clk);
    send_idle = si;
    recv_idle = ri;
    queue_random_pixels(n);
    drain_pixels();
  endtask

  int lo, hi;

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset scale: range edges, truncation near zero, breakpoints, point flag
    queue_pixel(-32768, 1'b0, 100, 1'b0, 1'b0);
    queue_pixel(32767, 1'b0, 1023, 1'b1, 1'b1);
    queue_pixel(-32768, 1'b1, 0, 1'b1, 1'b0);
    queue_pixel(0, 1'b0, 2, 1'b0, 1'b1);
    queue_pixel(-2000, 1'b0, 7, 1'b0, 1'b0);
    queue_pixel(-2001, 1'b1, 3, 1'b1, 1'b1);
    queue_pixel(-2019, 1'b0, 512, 1'b0, 1'b0);
    queue_pixel(-2020, 1'b0, 9, 1'b0, 1'b0);
    queue_pixel(6019, 1'b0, 40, 1'b1, 1'b0);
    queue_pixel(6020, 1'b1, 41, 1'b0, 1'b1);
    queue_pixel(-1001, 1'b0, 60, 1'b0, 1'b0);
    queue_pixel(-1000, 1'b0, 61, 1'b0, 1'b0);
    queue_pixel(1000, 1'b1, 62, 1'b0, 1'b0);
    queue_pixel(2000, 1'b0, 63, 1'b0, 1'b0);
    queue_pixel(5990, 1'b0, 1023, 1'b0, 1'b0);
    drain_pixels();
    run_phase(70, 1'b1, 1'b1);

    // quality bars in the bottom rows
    load_scale(-20, 60, 10, 20, 1'b1);
    @(negedge clk);
    queue_pixel(-32768, 1'b1, 0, 1'b0, 1'b1);
    queue_pixel(32767, 1'b0, 1, 1'b1, 1'b0);
    queue_pixel(0, 1'b1, 2, 1'b1, 1'b0);
    queue_pixel(0, 1'b0, 3, 1'b1, 1'b0);
    queue_pixel(0, 1'b1, 4, 1'b0, 1'b1);
    queue_pixel(-32768, 1'b0, 5, 1'b0, 1'b1);
    queue_pixel(0, 1'b1, 6, 1'b1, 1'b1);
    queue_pixel(32767, 1'b0, 1023, 1'b1, 1'b1);
    drain_pixels();
    run_phase(60, 1'b1, 1'b0);

    // widest scale with a reversed second segment
    load_scale(-128, 127, -128, 127, 1'b0);
    run_phase(70, 1'b1, 1'b1);

    // inverted bounds: everything out of range outside the bars
    load_scale(127, -128, 0, 0, 1'b1);
    run_phase(50, 1'b0, 1'b1);

    // single-index scale
    load_scale(0, 0, 0, 0, 1'b0);
    run_phase(50, 1'b1, 1'b1);

    // breakpoints out of order
    load_scale(-40, 40, 30, -10, 1'b0);
    run_phase(60, 1'b0, 1'b0);

    // random scales
    for (int ph = 0; ph < 4; ph++) begin
      lo = int'($urandom_range(0, 228)) - 128;
      hi = lo + int'($urandom_range(0, 127 - lo));
      if (ph == 3)
        hi = int'($urandom_range(0, 255)) - 128;
      load_scale(lo, hi, int'($urandom_range(0, 255)) - 128,
                 int'($urandom_range(0, 255)) - 128, 1'($urandom_range(0, 1)));
      run_phase(70, 1'b1, ph != 2);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
